### rtl/tlb_pkg.sv
// ----------------------------------------------------------------------------
// tlb_pkg
// Shared types and constants for the process-id tagged translation buffer.
// ----------------------------------------------------------------------------
package tlb_pkg;

   localparam int DEFAULT_MAX_ENTRIES = 16;
   localparam int ADDR_W  = 32;
   localparam int PID_W   = 16;
   localparam int FRAME_W = 16;
   localparam int PSIZE_W = 17;
   localparam int STAMP_W = 64;

   // replacement modes
   localparam logic [1:0] MODE_FIFO = 2'd0;
   localparam logic [1:0] MODE_LRU  = 2'd1;

   // configuration register indexes
   localparam logic [1:0] CSR_PAGE_SIZE = 2'd0;
   localparam logic [1:0] CSR_MODE      = 2'd1;
   localparam logic [1:0] CSR_ENTRIES   = 2'd2;

   localparam logic ACT_TRANSLATE = 1'b0;
   localparam logic ACT_FILL      = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] pid;
      logic [31:0] logical_address;
      logic [15:0] frame;
   } req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] physical_address;
      logic [31:0] page_index;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_MUL,
      ST_WRITE,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;       // capture request, start division
      logic div_step;   // one quotient bit
      logic scan_init;
      logic scan_step;  // examine one entry
      logic mul;        // form physical address
      logic write;      // commit fill / hit stamp
      logic respond;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic scan_done;
   } sts_type;

endpackage

### rtl/tlb_datapath.sv
// ----------------------------------------------------------------------------
// tlb_datapath
// Entry storage, restoring divider, serial entry scan and address multiply.
// ----------------------------------------------------------------------------
module tlb_datapath
   import tlb_pkg::*;
#(
   parameter int MaxEntries = DEFAULT_MAX_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  req_type             req_data,
   input  logic [PSIZE_W-1:0]  cfg_psize,
   input  logic [1:0]          mode,
   input  logic [4:0]          entries,
   output logic                rsp_strobe,
   output rsp_type             rsp_data
);

   localparam int IDX_W = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
   localparam int CNT_W = $clog2(MaxEntries + 1);

   // entry storage
   logic [MaxEntries-1:0] valid_ff;
   logic [PID_W-1:0]      pid_ff   [MaxEntries];
   logic [ADDR_W-1:0]     page_ff  [MaxEntries];
   logic [FRAME_W-1:0]    frame_ff [MaxEntries];
   logic [STAMP_W-1:0]    use_ff   [MaxEntries];
   logic [STAMP_W-1:0]    fill_ff  [MaxEntries];
   logic [STAMP_W-1:0]    time_ff;

   // request capture
   req_type               req_ff;
   logic [PSIZE_W-1:0]    psize_ff;
   logic [CNT_W-1:0]      n_ff;
   logic [1:0]            mode_ff;

   // divider
   logic [ADDR_W-1:0]     quot_ff;
   logic [PSIZE_W:0]      rem_ff;
   logic [5:0]            dcnt_ff;
   logic [PSIZE_W:0]      rem_shift;
   logic [PSIZE_W:0]      rem_sub;

   // scan
   logic [CNT_W-1:0]      sidx_ff;
   logic                  found_ff;
   logic                  inv_ff;
   logic [IDX_W-1:0]      sel_ff;
   logic [STAMP_W-1:0]    best_ff;

   // result
   logic [ADDR_W-1:0]     pa_ff;
   logic                  strobe_ff;
   rsp_type               rsp_ff;

   logic [CNT_W-1:0]      ent_sat;
   logic [IDX_W-1:0]      cur;
   logic                  match;
   logic [STAMP_W-1:0]    stamp;
   logic [FRAME_W-1:0]    frm;
   logic [47:0]           prod;

   assign ent_sat = (32'(entries) > MaxEntries) ? CNT_W'(MaxEntries) : CNT_W'(entries);
   assign rem_shift = {rem_ff[PSIZE_W-1:0], quot_ff[ADDR_W-1]};
   assign rem_sub   = rem_shift - {1'b0, psize_ff};
   assign cur   = sidx_ff[IDX_W-1:0];
   assign match = valid_ff[cur] && pid_ff[cur] == req_ff.pid
                  && page_ff[cur] == quot_ff;
   assign stamp = (mode_ff == MODE_FIFO) ? fill_ff[cur] : use_ff[cur];
   assign frm   = (req_ff.action == ACT_FILL) ? req_ff.frame : frame_ff[sel_ff];
   assign prod  = 48'(frm) * 48'(psize_ff) + 48'(rem_ff[PSIZE_W-1:0]);

   assign sts.div_done  = (dcnt_ff == 6'd32);
   assign sts.scan_done = (sidx_ff >= n_ff) || found_ff || inv_ff;

   // capture and divide (quotient shifts in where dividend shifts out)
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_data;
         psize_ff <= (cfg_psize == '0) ? PSIZE_W'(1) : cfg_psize;
         n_ff     <= ent_sat;
         mode_ff  <= mode;
         quot_ff  <= req_data.logical_address;
         rem_ff   <= '0;
         dcnt_ff  <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 6'd1;
         if (!rem_sub[PSIZE_W]) begin
            rem_ff  <= rem_sub;
            quot_ff <= {quot_ff[ADDR_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_shift;
            quot_ff <= {quot_ff[ADDR_W-2:0], 1'b0};
         end
      end
   end

   // serial scan: hit search on translate, victim search on fill
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         sidx_ff  <= '0;
         found_ff <= 1'b0;
         inv_ff   <= 1'b0;
         sel_ff   <= '0;
         best_ff  <= '0;
      end else if (cmd.scan_step) begin
         sidx_ff <= sidx_ff + CNT_W'(1);
         if (req_ff.action == ACT_TRANSLATE) begin
            if (match) begin
               found_ff <= 1'b1;
               sel_ff   <= cur;
            end
         end else if (!valid_ff[cur]) begin
            inv_ff <= 1'b1;
            sel_ff <= cur;
         end else if (sidx_ff == '0) begin
            best_ff <= stamp;
         end else if ((mode_ff == MODE_FIFO || mode_ff == MODE_LRU)
                      && stamp < best_ff) begin
            best_ff <= stamp;
            sel_ff  <= cur;
         end
      end
   end

   // physical address
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         pa_ff <= prod[ADDR_W-1:0];
      end
   end

   // entry update and time counter
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         time_ff  <= '0;
      end else if (cmd.write) begin
         if (req_ff.action == ACT_FILL) begin
            if (n_ff != '0) begin
               valid_ff[sel_ff] <= 1'b1;
               pid_ff[sel_ff]   <= req_ff.pid;
               page_ff[sel_ff]  <= quot_ff;
               frame_ff[sel_ff] <= req_ff.frame;
               use_ff[sel_ff]   <= time_ff;
               fill_ff[sel_ff]  <= time_ff;
               time_ff          <= time_ff + STAMP_W'(1);
            end
         end else if (found_ff) begin
            use_ff[sel_ff] <= time_ff;
            time_ff        <= time_ff + STAMP_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.respond;
      end
      if (cmd.respond) begin
         rsp_ff.hit <= (req_ff.action == ACT_FILL) || found_ff;
         rsp_ff.physical_address <= ((req_ff.action == ACT_FILL) || found_ff)
                                    ? pa_ff : '0;
         rsp_ff.page_index <= quot_ff;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // the counter only moves on a commit
   a_time_hold: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.write) |-> time_ff == $past(time_ff))
      else $error("time counter moved without write");
   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      dcnt_ff <= 6'd32 || $past(cmd.load) == 1'b0)
      else $error("divider overrun");
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.div_step) |-> rem_ff < {1'b0, psize_ff})
      else $error("remainder out of range");

endmodule

### rtl/tlb_control.sv
// ----------------------------------------------------------------------------
// tlb_control
// Sequencer: divide, scan entries, multiply, commit, respond.
// ----------------------------------------------------------------------------
module tlb_control
   import tlb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (sts.div_done) begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_SCAN: begin
            if (sts.scan_done) begin
               state_in = ST_MUL;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   a_one_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !cmd.respond)
      else $error("double response");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_DIVIDE)
      else $error("load did not start division");
   a_write_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> cmd.respond)
      else $error("write not followed by response");

endmodule

### rtl/tlb_translate_fifo_lru.sv
// ----------------------------------------------------------------------------
// tlb_translate_fifo_lru
// Process-id tagged fully associative TLB with FIFO / LRU / entry-zero refill.
// ----------------------------------------------------------------------------
// One transaction at a time: start is taken while busy is low, and the result
// appears for one cycle on rsp_valid after one-bit-per-cycle page division,
// a serial scan of up to n entries (n = entries in use, at most MaxEntries),
// then multiply, commit and respond, plus the result register. busy drops in
// the cycle the result is shown, so a new start can be taken while it is shown.
// The receiver cannot stall; take rsp_data when rsp_valid is high.
// The user must write configuration only while busy is low; the block
// itself does not enforce it.
module tlb_translate_fifo_lru
   import tlb_pkg::*;
#(
   parameter int MaxEntries = DEFAULT_MAX_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic [PSIZE_W-1:0] psize_ff;
   logic [1:0]         mode_ff;
   logic [4:0]         ent_ff;
   cmd_type            cmd;
   sts_type            sts;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         psize_ff <= PSIZE_W'(4096);
         mode_ff  <= MODE_FIFO;
         ent_ff   <= 5'd16;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PAGE_SIZE: psize_ff <= csr_wdata[PSIZE_W-1:0];
            CSR_MODE:      mode_ff  <= csr_wdata[1:0];
            CSR_ENTRIES:   ent_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   tlb_control u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   tlb_datapath #(.MaxEntries(MaxEntries)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_data),
      .cfg_psize  (psize_ff),
      .mode       (mode_ff),
      .entries    (ent_ff),
      .rsp_strobe (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

### sim/tlb_translate_fifo_lru_tb.sv
// ----------------------------------------------------------------------------
// tlb_translate_fifo_lru_tb
// Self-checking bench for the process-id tagged TLB. A queue of transactions
// is driven through the start/busy port while a shadow TLB predicts each
// response. Several page sizes, replacement modes and entry counts are used.
// ----------------------------------------------------------------------------
module tlb_translate_fifo_lru_tb;
   import tlb_pkg::*;

   localparam int NUM_ENT   = DEFAULT_MAX_ENTRIES;
   localparam int CYC_LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_data = '0;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_PAGE_SIZE;
   logic [31:0] csr_wdata = '0;

   tlb_translate_fifo_lru u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // shadow TLB
   logic [16:0]       sh_psize;
   logic [1:0]        sh_mode;
   logic [4:0]        sh_count;
   logic              sh_valid [NUM_ENT];
   logic [15:0]       sh_pid   [NUM_ENT];
   logic [31:0]       sh_page  [NUM_ENT];
   logic [15:0]       sh_frame [NUM_ENT];
   logic [63:0]       sh_use   [NUM_ENT];
   logic [63:0]       sh_fill  [NUM_ENT];
   logic [63:0]       sh_clock;

   req_type pending_reqs [$];
   rsp_type expected_rsps [$];
   int      n_sent = 0, n_rsp = 0, n_mismatch = 0, n_hits = 0;
   int      send_idle_pct = 0;
   int      cycles = 0;

   function automatic rsp_type translate_model(req_type r);
      rsp_type   o;
      logic [31:0] ps, pg, off;
      logic [63:0] pa;
      int n, v;
      ps  = (sh_psize == 0) ? 32'd1 : {15'd0, sh_psize};
      pg  = r.logical_address / ps;
      off = r.logical_address % ps;
      n   = (sh_count > NUM_ENT) ? NUM_ENT : sh_count;
      o   = '0;
      o.page_index = pg;
      if (r.action == ACT_TRANSLATE) begin
         for (int i = 0; i < n; i++) begin
            if (sh_valid[i] && sh_pid[i] == r.pid && sh_page[i] == pg) begin
               sh_use[i] = sh_clock;
               sh_clock++;
               pa = 64'(sh_frame[i]) * ps + off;
               o.hit = 1'b1;
               o.physical_address = pa[31:0];
               return o;
            end
         end
         return o;
      end
      if (n > 0) begin
         v = -1;
         for (int i = 0; i < n && v < 0; i++)
            if (!sh_valid[i]) v = i;
         if (v < 0) begin
            v = 0;
            if (sh_mode == MODE_FIFO) begin
               for (int i = 1; i < n; i++) if (sh_fill[i] < sh_fill[v]) v = i;
            end else if (sh_mode == MODE_LRU) begin
               for (int i = 1; i < n; i++) if (sh_use[i] < sh_use[v]) v = i;
            end
         end
         sh_valid[v] = 1'b1;
         sh_pid[v]   = r.pid;
         sh_page[v]  = pg;
         sh_frame[v] = r.frame;
         sh_use[v]   = sh_clock;
         sh_fill[v]  = sh_clock;
         sh_clock++;
      end
      pa = 64'(r.frame) * ps + off;
      o.hit = 1'b1;
      o.physical_address = pa[31:0];
      return o;
   endfunction

   // driver: one transaction per accepted start
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_rsps.push_back(translate_model(req_data));
            n_sent++;
         end
         if (!(start && busy)) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pending_reqs.pop_front();
               start    <= 1'b1;
            end else begin
               start    <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         n_rsp++;
         if (expected_rsps.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected response %h", rsp_data);
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (e.hit) n_hits++;
            if (e !== rsp_data) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch: exp hit=%b pa=%h pg=%h got hit=%b pa=%h pg=%h",
                           e.hit, e.physical_address, e.page_index, rsp_data.hit,
                           rsp_data.physical_address, rsp_data.page_index);
            end
         end
      end
      if (cycles > CYC_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PAGE_SIZE) sh_psize = val[16:0];
      else if (idx == CSR_MODE) sh_mode = val[1:0];
      else if (idx == CSR_ENTRIES) sh_count = val[4:0];
   endtask

   // wait until every queued transaction has been answered
   task automatic drain();
      while (pending_reqs.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function automatic req_type mk(logic act, logic [15:0] pid, logic [31:0] la,
                                  logic [15:0] fr);
      req_type r;
      r.action = act; r.pid = pid; r.logical_address = la; r.frame = fr;
      return r;
   endfunction

   // random phase: small working set of pids/pages so hits and evictions occur
   task automatic random_phase(int cnt);
      req_type r;
      logic [31:0] ps;
      for (int k = 0; k < cnt; k++) begin
         ps = (sh_psize == 0) ? 32'd1 : {15'd0, sh_psize};
         if ($urandom_range(9) < 8) begin
            r.action = logic'($urandom_range(1));
            r.pid    = 16'($urandom_range(3)) ^ ($urandom_range(7) == 0 ? 16'hFFFF : 16'h0);
            r.logical_address = 32'($urandom_range(24)) * ps + ($urandom % ps);
            r.frame  = 16'($urandom);
         end else begin
            r = mk(logic'($urandom_range(1)), 16'($urandom), $urandom, 16'($urandom));
         end
         pending_reqs.push_back(r);
      end
   endtask

   initial begin
      sh_psize = 17'd4096; sh_mode = MODE_FIFO; sh_count = 5'd16; sh_clock = '0;
      for (int i = 0; i < NUM_ENT; i++) begin
         sh_valid[i] = 1'b0; sh_pid[i] = '0; sh_page[i] = '0; sh_frame[i] = '0;
         sh_use[i] = '0; sh_fill[i] = '0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, duplicate fill, miss
      send_idle_pct = 25;
      pending_reqs.push_back(mk(ACT_TRANSLATE, 16'h0000, 32'h0000_0000, 16'h0));
      pending_reqs.push_back(mk(ACT_FILL, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF));
      pending_reqs.push_back(mk(ACT_FILL, 16'hFFFF, 32'hFFFF_F000, 16'h1234));
      pending_reqs.push_back(mk(ACT_TRANSLATE, 16'hFFFF, 32'hFFFF_FABC, 16'h0));
      pending_reqs.push_back(mk(ACT_TRANSLATE, 16'hFFFE, 32'hFFFF_FABC, 16'h0));
      pending_reqs.push_back(mk(ACT_FILL, 16'h0000, 32'h0000_0000, 16'h0000));
      drain();
      // page size zero, oversize count, unused mode
      csr_write(CSR_PAGE_SIZE, 32'd0);
      csr_write(CSR_ENTRIES, 32'd31);
      csr_write(CSR_MODE, 32'd3);
      for (int k = 0; k < 18; k++)
         pending_reqs.push_back(mk(ACT_FILL, 16'(k), 32'(k), 16'(k)));
      pending_reqs.push_back(mk(ACT_TRANSLATE, 16'd17, 32'd17, 16'h0));
      drain();
      // disabled TLB
      csr_write(CSR_ENTRIES, 32'd0);
      pending_reqs.push_back(mk(ACT_FILL, 16'd5, 32'd5, 16'd9));
      pending_reqs.push_back(mk(ACT_TRANSLATE, 16'd5, 32'd5, 16'd0));
      drain();

      // random phases over several settings
      for (int ph = 0; ph < 12; ph++) begin
         send_idle_pct = (ph < 4) ? 25 : (ph < 8) ? 60 : 0;
         case (ph % 4)
            0: csr_write(CSR_PAGE_SIZE, 32'd1);
            1: csr_write(CSR_PAGE_SIZE, 32'd65536);
            2: csr_write(CSR_PAGE_SIZE, 32'h1FFFF);
            default: csr_write(CSR_PAGE_SIZE, 32'($urandom_range(65536, 1)));
         endcase
         csr_write(CSR_MODE, 32'(ph % 3));
         csr_write(CSR_ENTRIES, (ph % 5 == 4) ? 32'd16 : 32'($urandom_range(16)));
         random_phase(125);
         drain();
      end

      $display("sent %0d transactions, %0d responses, %0d with hit set",
               n_sent, n_rsp, n_hits);
      if (n_mismatch == 0 && expected_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
